>>> rtl/msr_pkg.sv
// shared constants and types for the motor speed ramp block
`default_nettype none
package msr_pkg;

    // command kinds carried on the input tuser
    localparam logic [2:0] FUNC_SET   = 3'd0;
    localparam logic [2:0] FUNC_RAMP  = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_ESTOP = 3'd3;
    localparam logic [2:0] FUNC_BRAKE = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_TRIM  = 2'd0;
    localparam logic [1:0] REG_FLOOR = 2'd1;
    localparam logic [1:0] REG_STEP  = 2'd2;

    localparam int SPEED_MAX      = 255;
    localparam int TRIM_LIMIT     = 50;
    localparam int DEADBAND_LIMIT = 150;
    localparam int STEP_RESET     = 10;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 16;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // floor(x / 100) = (x * 5243) >> 19 for x below 2^14
    localparam logic [MUL_B_W-1:0] RECIP_100   = 17'd5243;
    localparam int                 SHIFT_100   = 19;
    // floor(x / 254) = (x * 66053) >> 24 for x below 2^16
    localparam logic [MUL_B_W-1:0] RECIP_254   = 17'd66053;
    localparam int                 SHIFT_254   = 24;

    // one result as it sits in the output register
    typedef struct packed {
        logic       estop_active;
        logic [8:0] speed_now;
        logic       dir_reverse_pin;
        logic       dir_forward_pin;
        logic [7:0] pwm_duty;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/msr_mul.sv
// shared unsigned multiplier with registered product
`default_nettype none
module msr_mul (
    input  wire logic                        aclk,
    input  wire logic [msr_pkg::MUL_A_W-1:0] a_in,
    input  wire logic [msr_pkg::MUL_B_W-1:0] b_in,
    output logic      [msr_pkg::MUL_P_W-1:0] prod_out
);
    import msr_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= MUL_P_W'(a_in) * MUL_P_W'(b_in);
    end

    assign prod_out = prod_reg;

endmodule
`default_nettype wire

>>> rtl/motor_speed_ramp_trim_deadband_core.sv
// top level: h-bridge command sequencer with ramp, trim and deadband mapping
`default_nettype none
// Takes one motor command per request (kind on s_tuser, signed speed on s_tdata)
// and returns one result, or two for brake, on the m_ side with tlast marking
// the final one. Set speed and ramp step pass through one shared 16x17
// multiplier four times (trim product, divide by 100, deadband scale, divide
// by 254), or only the first two when the trimmed speed is zero; stop,
// emergency stop, brake and ignored commands do not use it. Each result step
// waits further while the previous result still sits unaccepted on m_tready.
// The block takes no new command while one is in work, but does take one
// while a finished result still waits on m_tready.
// Configuration writes are taken at any time and saturate into range; write
// only while idle. The emergency latch is cleared by reset only.
module motor_speed_ramp_trim_deadband_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // command request
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // [15:0] speed_command
    input  wire logic [2:0]  s_tuser,    // [2:0] func
    // result request
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // [7:0] pwm_duty, [8] dir_forward_pin,
                                         // [9] dir_reverse_pin, [18:10] speed_now,
                                         // [19] estop_active, [23:20] zero
    output logic             m_tlast,    // last_of_run
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import msr_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;  // |trim| * |speed|
    localparam logic [3:0] S_MUL2 = 4'd3;  // product / 100
    localparam logic [3:0] S_ADD  = 4'd4;  // add trim, clamp, set pins
    localparam logic [3:0] S_MUL3 = 4'd5;  // (mag - 1) * (255 - floor)
    localparam logic [3:0] S_MUL4 = 4'd6;  // scaled / 254
    localparam logic [3:0] S_FIN  = 4'd7;  // add floor
    localparam logic [3:0] S_BRK  = 4'd8;  // brake pulse result
    localparam logic [3:0] S_EMIT = 4'd9;  // final result

    // control and architectural state
    logic [3:0]        state_reg, state_next;
    logic signed [8:0] cur_reg, cur_next;
    logic              latch_reg, latch_next;
    logic [7:0]        duty_reg, duty_next;
    logic              pin_a_reg, pin_a_next;
    logic              pin_b_reg, pin_b_next;
    logic signed [6:0] trim_reg, trim_next;
    logic [7:0]        floor_reg, floor_next;
    logic [7:0]        step_reg, step_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // payload
    logic [2:0]        func_reg, func_next;
    logic signed [15:0] cmd_reg, cmd_next;
    logic signed [8:0] s_reg, s_next;
    logic [7:0]        mag_reg, mag_next;
    result_t           res_reg, res_next;
    logic              m_tlast_reg, m_tlast_next;

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;

    msr_mul u_mul (
        .aclk     (aclk),
        .a_in     (mul_a),
        .b_in     (mul_b),
        .prod_out (prod)
    );

    // datapath helpers
    logic signed [8:0]  tgt;
    logic signed [10:0] up_sum, dn_sum;
    logic signed [8:0]  ramp_speed;
    logic [7:0]         s_mag;
    logic [5:0]         trim_mag;
    logic [6:0]         quot;
    logic signed [10:0] t_wide;
    logic signed [8:0]  t_clamped;
    logic               out_free;
    logic signed [6:0]  cfg_trim;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {4'd0, res_reg};
    assign m_tlast   = m_tlast_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        // clamp the raw command to the speed range
        if (cmd_reg > 16'sd255) begin
            tgt = 9'sd255;
        end else if (cmd_reg < -16'sd255) begin
            tgt = -9'sd255;
        end else begin
            tgt = cmd_reg[8:0];
        end
        // move current speed at most one step toward the target
        up_sum = 11'(cur_reg) + $signed({3'b000, step_reg});
        dn_sum = 11'(cur_reg) - $signed({3'b000, step_reg});
        if (cur_reg < tgt) begin
            ramp_speed = (up_sum < 11'(tgt)) ? up_sum[8:0] : tgt;
        end else if (cur_reg > tgt) begin
            ramp_speed = (dn_sum > 11'(tgt)) ? dn_sum[8:0] : tgt;
        end else begin
            ramp_speed = cur_reg;
        end

        s_mag    = s_reg[8] ? 8'(-s_reg) : s_reg[7:0];
        trim_mag = trim_reg[6] ? 6'(-trim_reg) : trim_reg[5:0];

        // truncating divide: quotient of the magnitude, sign applied after
        quot   = prod[SHIFT_100 +: 7];
        t_wide = (trim_reg[6] ^ s_reg[8]) ? 11'(s_reg) - $signed({4'b0000, quot})
                                          : 11'(s_reg) + $signed({4'b0000, quot});
        if (t_wide > 11'sd255) begin
            t_clamped = 9'sd255;
        end else if (t_wide < -11'sd255) begin
            t_clamped = -9'sd255;
        end else begin
            t_clamped = t_wide[8:0];
        end

        cfg_trim = $signed(cfg_data[6:0]);
    end

    // operand select for the shared multiplier
    always_comb begin
        case (state_reg)
            S_MUL1: begin
                mul_a = MUL_A_W'(trim_mag);
                mul_b = MUL_B_W'(s_mag);
            end
            S_MUL2: begin
                mul_a = MUL_A_W'(prod[13:0]);
                mul_b = RECIP_100;
            end
            S_MUL3: begin
                mul_a = MUL_A_W'(mag_reg - 8'd1);
                mul_b = MUL_B_W'(8'd255 - floor_reg);
            end
            S_MUL4: begin
                mul_a = prod[MUL_A_W-1:0];
                mul_b = RECIP_254;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        latch_next    = latch_reg;
        duty_next     = duty_reg;
        pin_a_next    = pin_a_reg;
        pin_b_next    = pin_b_reg;
        trim_next     = trim_reg;
        floor_next    = floor_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        func_next     = func_reg;
        cmd_next      = cmd_reg;
        s_next        = s_reg;
        mag_next      = mag_reg;
        res_next      = res_reg;
        m_tlast_next  = m_tlast_reg;

        // downstream took the held result
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // configuration writes saturate into range
        if (cfg_valid) begin
            case (cfg_index)
                REG_TRIM: begin
                    if (cfg_trim > 7'sd50) begin
                        trim_next = 7'sd50;
                    end else if (cfg_trim < -7'sd50) begin
                        trim_next = -7'sd50;
                    end else begin
                        trim_next = cfg_trim;
                    end
                end
                REG_FLOOR: begin
                    floor_next = (cfg_data > 8'(DEADBAND_LIMIT)) ? 8'(DEADBAND_LIMIT)
                                                                   : cfg_data;
                end
                REG_STEP: begin
                    step_next = (cfg_data == 8'd0) ? 8'd1 : cfg_data;
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tuser;
                    cmd_next   = $signed(s_tdata);
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                state_next = S_EMIT;
                case (func_reg)
                    FUNC_SET: begin
                        if (!latch_reg) begin
                            s_next     = tgt;
                            state_next = S_MUL1;
                        end
                    end
                    FUNC_RAMP: begin
                        if (!latch_reg) begin
                            s_next     = ramp_speed;
                            state_next = S_MUL1;
                        end
                    end
                    FUNC_STOP: begin
                        cur_next  = '0;
                        duty_next = '0;
                    end
                    FUNC_ESTOP: begin
                        latch_next = 1'b1;
                        cur_next   = '0;
                        duty_next  = '0;
                        pin_a_next = 1'b0;
                        pin_b_next = 1'b0;
                    end
                    FUNC_BRAKE: begin
                        duty_next  = 8'd255;
                        pin_a_next = 1'b1;
                        pin_b_next = 1'b1;
                        state_next = S_BRK;
                    end
                    default: begin
                    end
                endcase
            end
            S_MUL1: begin
                state_next = S_MUL2;
            end
            S_MUL2: begin
                state_next = S_ADD;
            end
            S_ADD: begin
                cur_next   = t_clamped;
                pin_a_next = !t_clamped[8];
                pin_b_next = t_clamped[8];
                mag_next   = t_clamped[8] ? 8'(-t_clamped) : t_clamped[7:0];
                if (t_clamped == 9'sd0) begin
                    duty_next  = '0;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_MUL3;
                end
            end
            S_MUL3: begin
                state_next = S_MUL4;
            end
            S_MUL4: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                duty_next  = prod[SHIFT_254 +: 8] + floor_reg;
                state_next = S_EMIT;
            end
            S_BRK: begin
                // full-duty pulse, then fall into a stop
                if (out_free) begin
                    res_next      = '{latch_reg, cur_reg, pin_b_reg, pin_a_reg, duty_reg};
                    m_tlast_next  = 1'b0;
                    m_tvalid_next = 1'b1;
                    cur_next      = '0;
                    duty_next     = '0;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    res_next      = '{latch_reg, cur_reg, pin_b_reg, pin_a_reg, duty_reg};
                    m_tlast_next  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cur_reg      <= '0;
            latch_reg    <= 1'b0;
            duty_reg     <= '0;
            pin_a_reg    <= 1'b0;
            pin_b_reg    <= 1'b0;
            trim_reg     <= '0;
            floor_reg    <= '0;
            step_reg     <= 8'(STEP_RESET);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            latch_reg    <= latch_next;
            duty_reg     <= duty_next;
            pin_a_reg    <= pin_a_next;
            pin_b_reg    <= pin_b_next;
            trim_reg     <= trim_next;
            floor_reg    <= floor_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        cmd_reg     <= cmd_next;
        s_reg       <= s_next;
        mag_reg     <= mag_next;
        res_reg     <= res_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule
`default_nettype wire

>>> dv/motor_speed_ramp_trim_deadband_core_tb.sv
// testbench for the h-bridge speed ramp, trim and deadband block
`default_nettype none
module motor_speed_ramp_trim_deadband_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msr_pkg::*;

    // spare command kinds above brake are ignored by the block
    localparam logic [2:0] FUNC_TOP_CODE = 3'd7;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         PHASE_ITEMS   = 195;

    // predicts the result requests of each accepted command
    class bridge_command_model;
        typedef struct {
            result_t res;
            logic    last;
        } bridge_result_t;

        int             trim_pct;
        int             duty_floor;
        int             step_size;
        int             speed_cur;
        int             speed_goal;
        bit             latched;
        logic [7:0]     duty;
        logic           pin_fwd;
        logic           pin_rev;
        bridge_result_t results_due[$];
        int             mismatches;

        function new();
            trim_pct   = 0;
            duty_floor = 0;
            step_size  = STEP_RESET;
            speed_cur  = 0;
            speed_goal = 0;
            latched    = 1'b0;
            duty       = 8'd0;
            pin_fwd    = 1'b0;
            pin_rev    = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] data);
            int v;
            case (idx)
                REG_TRIM: begin
                    v = $signed(data[6:0]);
                    if (v > TRIM_LIMIT) v = TRIM_LIMIT;
                    if (v < -TRIM_LIMIT) v = -TRIM_LIMIT;
                    trim_pct = v;
                end
                REG_FLOOR: duty_floor = (data > DEADBAND_LIMIT) ? DEADBAND_LIMIT : data;
                REG_STEP:  step_size = (data == 8'd0) ? 1 : data;
                default: ;
            endcase
        endfunction

        function int clamp_speed(int v);
            if (v > SPEED_MAX) return SPEED_MAX;
            if (v < -SPEED_MAX) return -SPEED_MAX;
            return v;
        endfunction

        // trim division truncates toward zero
        function int trim_speed(int s);
            if (s == 0) return 0;
            return clamp_speed(s + (trim_pct * s) / 100);
        endfunction

        // 1..255 onto floor..255, zero stays zero
        function logic [7:0] duty_for(int mag);
            if (mag == 0) return 8'd0;
            return 8'(((mag - 1) * (255 - duty_floor)) / 254 + duty_floor);
        endfunction

        function void drive_speed(int s);
            int t;
            t          = trim_speed(clamp_speed(s));
            pin_fwd    = (t >= 0);
            pin_rev    = (t < 0);
            duty       = duty_for((t < 0) ? -t : t);
            speed_cur  = t;
            speed_goal = t;
        endfunction

        function void push_result(logic last);
            bridge_result_t r;
            r.res.estop_active    = latched;
            r.res.speed_now       = speed_cur[8:0];
            r.res.dir_reverse_pin = pin_rev;
            r.res.dir_forward_pin = pin_fwd;
            r.res.pwm_duty        = duty;
            r.last                = last;
            results_due.push_back(r);
        endfunction

        function void take_command(logic [2:0] func, logic signed [15:0] cmd);
            int c;
            int n;
            c = cmd;
            case (func)
                FUNC_SET: if (!latched) drive_speed(c);
                FUNC_RAMP: begin
                    if (!latched) begin
                        speed_goal = clamp_speed(c);
                        if (speed_cur < speed_goal) begin
                            n = speed_cur + step_size;
                            speed_cur = (n < speed_goal) ? n : speed_goal;
                        end else if (speed_cur > speed_goal) begin
                            n = speed_cur - step_size;
                            speed_cur = (n > speed_goal) ? n : speed_goal;
                        end
                        drive_speed(speed_cur);
                    end
                end
                FUNC_STOP: begin
                    speed_cur  = 0;
                    speed_goal = 0;
                    duty       = 8'd0;
                end
                FUNC_ESTOP: begin
                    latched    = 1'b1;
                    speed_cur  = 0;
                    speed_goal = 0;
                    pin_fwd    = 1'b0;
                    pin_rev    = 1'b0;
                    duty       = 8'd0;
                end
                FUNC_BRAKE: begin
                    // full-duty pulse, then a stop with both pins still high
                    pin_fwd = 1'b1;
                    pin_rev = 1'b1;
                    duty    = 8'd255;
                    push_result(1'b0);
                    speed_cur  = 0;
                    speed_goal = 0;
                    duty       = 8'd0;
                    push_result(1'b1);
                    return;
                end
                default: ;
            endcase
            push_result(1'b1);
        endfunction

        function void check_result(logic [23:0] data, logic last);
            bridge_result_t e;
            result_t        got;
            got = data[19:0];
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none due: data %h last %0b", $realtime, data,
                             last);
                return;
            end
            e = results_due.pop_front();
            if (got !== e.res || data[23:20] !== 4'd0 || last !== e.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected duty %0d fwd %0b rev %0b speed %0d estop %0b last %0b",
                             e.res.pwm_duty, e.res.dir_forward_pin, e.res.dir_reverse_pin,
                             $signed(e.res.speed_now), e.res.estop_active, e.last);
                    $display("  actual   duty %0d fwd %0b rev %0b speed %0d estop %0b last %0b",
                             got.pwm_duty, got.dir_forward_pin, got.dir_reverse_pin,
                             $signed(got.speed_now), got.estop_active, last);
                    $display("  actual   pad %h", data[23:20]);
                end
            end
        endfunction

        function int outstanding();
            return results_due.size();
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'd0;
    logic [2:0]  s_tuser   = FUNC_STOP;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_TRIM;
    logic [7:0]  cfg_data  = 8'd0;

    bridge_command_model model = new();

    // idling knobs, changed per phase; calm turns all idling off
    bit calm        = 1'b0;
    int src_gap_pct = 0;
    int sink_pct    = 0;
    int stall_left  = 0;
    int quiet_cycles = 0;

    // register settings for the first fixed phases, out-of-range values included
    logic [7:0] trim_raw  [4] = '{8'd50, 8'hCE, 8'h3F, 8'h40};
    logic [7:0] floor_raw [4] = '{8'd150, 8'd0, 8'hFF, 8'd151};
    logic [7:0] step_raw  [4] = '{8'd255, 8'd1, 8'd0, 8'd128};

    motor_speed_ramp_trim_deadband_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: check every accepted result, stall in random bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) model.check_result(m_tdata, m_tlast);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < sink_pct) begin
                stall_left = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: too long without any request moving on any channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic signed [15:0] pick_speed();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 600)) - 300;
            6: v = $urandom();
            7: v = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(254, 256));
            8: v = 0;
            default: v = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, 3));
        endcase
        return 16'(v);
    endfunction

    task automatic send_command(logic [2:0] func, logic signed [15:0] cmd);
        if (!calm && $urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model.take_command(func, cmd);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        model.write_reg(idx, data);
    endtask

    // let every due result come back, then give the block time to settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (model.outstanding() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic pick_spare(output logic [2:0] func);
        func = 3'($urandom_range(FUNC_BRAKE + 1, FUNC_TOP_CODE));
    endtask

    // mostly set speeds and ramp runs toward one target, with stops, brakes
    // and spare codes mixed in
    task automatic random_commands(int count, bit allow_estop);
        int               left;
        int               steps;
        int               roll;
        logic signed [15:0] goal;
        logic [2:0]       spare;
        left = count;
        while (left > 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                send_command(FUNC_SET, pick_speed());
                left--;
            end else if (roll < 75) begin
                goal  = pick_speed();
                steps = $urandom_range(1, 25);
                repeat (steps) begin
                    if ($urandom_range(0, 9) == 0) send_command(FUNC_RAMP, pick_speed());
                    else send_command(FUNC_RAMP, goal);
                end
                left -= steps;
            end else if (roll < 84) begin
                send_command(FUNC_STOP, 16'($urandom()));
                left--;
            end else if (roll < 93) begin
                send_command(FUNC_BRAKE, 16'($urandom()));
                left--;
            end else if (roll < 97 || !allow_estop) begin
                pick_spare(spare);
                send_command(spare, 16'($urandom()));
                left--;
            end else begin
                send_command(FUNC_ESTOP, 16'($urandom()));
                left--;
            end
        end
    endtask

    initial begin
        logic [2:0] spare;
        // reset, held once at the start
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed commands under the reset settings
        send_command(FUNC_SET, 16'sd0);
        send_command(FUNC_SET, 16'sh7FFF);
        send_command(FUNC_SET, 16'sh8000);
        send_command(FUNC_SET, 16'sd255);
        send_command(FUNC_SET, -16'sd255);
        send_command(FUNC_SET, 16'sd1);
        send_command(FUNC_SET, -16'sd1);
        // stop keeps the reverse pin from the last set
        send_command(FUNC_STOP, 16'sd77);
        repeat (3) send_command(FUNC_RAMP, 16'sd100);
        repeat (2) send_command(FUNC_RAMP, -16'sd40);
        send_command(FUNC_RAMP, 16'sh7FFF);
        send_command(FUNC_BRAKE, 16'sd5);
        for (int k = FUNC_BRAKE + 1; k <= FUNC_TOP_CODE; k++) send_command(3'(k), 16'shFFFF);
        send_command(FUNC_SET, 16'sd128);
        send_command(FUNC_STOP, 16'sd0);
        send_command(FUNC_RAMP, -16'sd300);

        src_gap_pct = 25;
        sink_pct    = 25;
        random_commands(PHASE_ITEMS, 1'b0);

        // register phases: extremes, saturating writes, then random bytes
        for (int p = 0; p < 8; p++) begin
            drain();
            if (p < 4) begin
                write_reg(REG_TRIM, trim_raw[p]);
                write_reg(REG_FLOOR, floor_raw[p]);
                write_reg(REG_STEP, step_raw[p]);
            end else begin
                write_reg(REG_STEP, 8'($urandom()));
                write_reg(REG_TRIM, 8'($urandom()));
                write_reg(REG_FLOOR, 8'($urandom()));
            end
            cfg_valid <= 1'b0;
            src_gap_pct = $urandom_range(0, 2) * 25;
            sink_pct    = $urandom_range(0, 2) * 25;
            random_commands(PHASE_ITEMS, 1'b0);
        end

        // last part, no idling: latch the emergency stop and keep commanding
        calm = 1'b1;
        send_command(FUNC_ESTOP, 16'sd0);
        send_command(FUNC_SET, 16'sd200);
        send_command(FUNC_RAMP, -16'sd200);
        send_command(FUNC_STOP, 16'sd0);
        send_command(FUNC_BRAKE, 16'sd0);
        pick_spare(spare);
        send_command(spare, 16'sd9);
        random_commands(60, 1'b1);
        s_tvalid <= 1'b0;

        while (model.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (model.mismatches == 0 && model.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
rtl/msr_pkg.sv
rtl/msr_mul.sv
rtl/motor_speed_ramp_trim_deadband_core.sv
dv/motor_speed_ramp_trim_deadband_core_tb.sv
